// ----- rtl/core/axis_angle_rotation_matrix_assert.svh -----
// Assertion macros used by the checker module of the rotation matrix block.
// Needs a clock named clock and a reset named reset in the module that uses them.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define AARM_ASSERT_IMPL(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("rotation matrix check failed");

// Next-cycle implication, checked outside of reset.
`define AARM_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rotation matrix check failed");

`endif

// ----- rtl/core/aarm_pkg.sv -----
// Package of the axis-angle rotation matrix block: widths, constants, types.
// Used by every module of the block but aarm_checker; depends on nothing.
`default_nettype none

package aarm_pkg;

   // Defaults of the top level parameters.
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 14;

   // Port widths.
   localparam int IN_DATA_W  = 72;
   localparam int OUT_DATA_W = 168;
   localparam int ANGLE_W    = 18;
   localparam int AXIS_W     = 16;
   localparam int ENTRY_W    = 18;
   localparam int NUM_ENTRY  = 9;

   // CORDIC datapath width, Q2.30 with headroom.
   localparam int CW = 34;

   // Angle limits in 1/256 degree.
   localparam logic signed [18:0] ANGLE_LIMIT = 19'sd92160;
   localparam logic signed [18:0] DEG360      = 19'sd92160;
   localparam logic signed [18:0] DEG180      = 19'sd46080;
   localparam logic signed [18:0] DEG90       = 19'sd23040;

   // pi in Q2.30 split as 46080 * Q_MUL + R_MUL.
   localparam logic [16:0] Q_MUL   = 17'd73204;
   localparam logic [14:0] R_MUL   = 15'd19106;
   localparam logic [29:0] R_HALF  = 30'd23040;
   // floor(2^25 / 45), corrected by one compare afterwards.
   localparam logic [19:0] DIV45_MUL = 20'd745654;
   localparam int          DIV45_SH  = 25;
   localparam logic [20:0] DIV45_K   = 21'd45;

   // CORDIC start value 1/K in Q2.30.
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   // Output saturation limits.
   localparam int OUT_MAX = 131071;

   // Side data that rides along with the angle.
   typedef struct packed {
      logic               flip;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
   } aux_type;

   // One word between CORDIC cells.
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      aux_type              aux;
   } cordic_type;

   // atan(2^-i) in Q2.30.
   function automatic logic signed [CW-1:0] atan_q30(input int idx);
      logic signed [CW-1:0] v;
      case (idx)
         0:  v = 34'sh03243F6A8;
         1:  v = 34'sh01DAC6705;
         2:  v = 34'sh00FADBAFC;
         3:  v = 34'sh007F56EA6;
         4:  v = 34'sh003FEAB76;
         5:  v = 34'sh001FFD55B;
         6:  v = 34'sh000FFFAAA;
         7:  v = 34'sh0007FFF55;
         8:  v = 34'sh0003FFFEA;
         9:  v = 34'sh0001FFFFD;
         10: v = 34'sh0000FFFFF;
         11: v = 34'sh00007FFFF;
         12: v = 34'sh00003FFFF;
         13: v = 34'sh00001FFFF;
         14: v = 34'sh00000FFFF;
         15: v = 34'sh000007FFF;
         16: v = 34'sh000003FFF;
         17: v = 34'sh000001FFF;
         18: v = 34'sh000000FFF;
         19: v = 34'sh0000007FF;
         20: v = 34'sh0000003FF;
         21: v = 34'sh0000001FF;
         22: v = 34'sh0000000FF;
         23: v = 34'sh00000007F;
         24: v = 34'sh00000003F;
         25: v = 34'sh00000001F;
         26: v = 34'sh00000000F;
         27: v = 34'sh000000007;
         28: v = 34'sh000000003;
         29: v = 34'sh000000001;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/aarm_front.sv -----
// Angle front end: clamp, fold into [-90, 90] degrees, convert to Q2.30 radians.
// Three pipeline stages; depends on aarm_pkg.
`default_nettype none

module aarm_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic signed [17:0]        angle,
   input  wire logic signed [15:0]        ax,
   input  wire logic signed [15:0]        ay,
   input  wire logic signed [15:0]        az,
   output logic                           out_valid,
   output aarm_pkg::cordic_type           out_word
);
   import aarm_pkg::*;

   logic signed [18:0] a_clamp, a_wrap, a_fold;
   logic               flip;
   logic [14:0]        mag;

   logic        va_ff, vb_ff, vc_ff;
   logic [30:0] mq_a_ff, mq_b_ff;
   logic [28:0] mr_ff;
   logic        neg_a_ff, neg_b_ff;
   aux_type     aux_a_ff, aux_b_ff;
   logic [19:0] m_ff;
   logic [39:0] p_ff;
   cordic_type  out_ff;

   logic [29:0] n_in;
   logic [19:0] m_in;
   logic [14:0] q;
   logic [20:0] r;
   logic [14:0] qc;
   logic signed [CW-1:0] z_pos;

   // Clamp, then fold whole turns and the half turn.
   always_comb begin
      a_clamp = 19'(angle);
      if (a_clamp > ANGLE_LIMIT) begin
         a_clamp = ANGLE_LIMIT;
      end
      if (a_clamp < -ANGLE_LIMIT) begin
         a_clamp = -ANGLE_LIMIT;
      end
      a_wrap = a_clamp;
      if (a_clamp > DEG180) begin
         a_wrap = a_clamp - DEG360;
      end else if (a_clamp < -DEG180) begin
         a_wrap = a_clamp + DEG360;
      end
      a_fold = a_wrap;
      flip   = 1'b0;
      if (a_wrap > DEG90) begin
         a_fold = DEG180 - a_wrap;
         flip   = 1'b1;
      end else if (a_wrap < -DEG90) begin
         a_fold = -DEG180 - a_wrap;
         flip   = 1'b1;
      end
      mag = (a_fold < 0) ? 15'(-a_fold) : 15'(a_fold);
   end

   // Stage B and C arithmetic: divide the remainder part by 46080.
   always_comb begin
      n_in  = 30'(mr_ff) + R_HALF;
      m_in  = n_in[29:10];
      q     = p_ff[DIV45_SH+14:DIV45_SH];
      r     = 21'(m_ff) - 21'(q) * DIV45_K;
      qc    = (r >= DIV45_K) ? q + 15'd1 : q;
      z_pos = CW'(mq_b_ff) + CW'(qc);
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   // Payload of the three stages.
   always_ff @(posedge clock) begin
      if (en) begin
         mq_a_ff  <= 31'(mag) * 31'(Q_MUL);
         mr_ff    <= 29'(mag) * 29'(R_MUL);
         neg_a_ff <= a_fold < 0;
         aux_a_ff <= '{flip: flip, ax: ax, ay: ay, az: az};

         mq_b_ff  <= mq_a_ff;
         m_ff     <= m_in;
         p_ff     <= 40'(m_in) * 40'(DIV45_MUL);
         neg_b_ff <= neg_a_ff;
         aux_b_ff <= aux_a_ff;

         out_ff.x   <= CORDIC_GAIN;
         out_ff.y   <= '0;
         out_ff.z   <= neg_b_ff ? -z_pos : z_pos;
         out_ff.aux <= aux_b_ff;
      end
   end

   assign out_valid = vc_ff;
   assign out_word  = out_ff;

endmodule

`default_nettype wire

// ----- rtl/core/aarm_cordic_cell.sv -----
// One CORDIC rotation cell with a fixed shift and arctangent constant.
// Registers its word every enabled cycle; depends on aarm_pkg.
`default_nettype none

module aarm_cordic_cell #(
   parameter int IDX = 0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  aarm_pkg::cordic_type in_word,
   output logic                 out_valid,
   output aarm_pkg::cordic_type out_word
);
   import aarm_pkg::*;

   localparam logic signed [CW-1:0] ATAN = atan_q30(IDX);

   logic signed [CW-1:0] dx, dy;
   cordic_type           out_in, out_ff;
   logic                 valid_ff;

   // Rotate toward a zero residual; zero counts as positive.
   always_comb begin
      dx     = in_word.y >>> IDX;
      dy     = in_word.x >>> IDX;
      out_in = in_word;
      if (!in_word.z[CW-1]) begin
         out_in.x = in_word.x - dx;
         out_in.y = in_word.y + dy;
         out_in.z = in_word.z - ATAN;
      end else begin
         out_in.x = in_word.x + dx;
         out_in.y = in_word.y - dy;
         out_in.z = in_word.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = out_ff;

endmodule

`default_nettype wire

// ----- rtl/core/aarm_matrix.sv -----
// Matrix back end: rounds sine and cosine, forms the nine Rodrigues terms,
// rounds and saturates them. Four stages, the last is the output register.
`default_nettype none

module aarm_matrix #(
   parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  aarm_pkg::cordic_type         in_word,
   output logic                         out_valid,
   output logic signed [17:0]           entry [9]
);
   import aarm_pkg::*;

   localparam int RS = 30 - FRAC_BITS;
   localparam int FW = FRAC_BITS + 3;
   localparam int SW = FRAC_BITS + 38;
   localparam int OS = FRAC_BITS + 14;
   localparam logic signed [CW-1:0] HALF_R = CW'(1) <<< (RS - 1);
   localparam logic signed [SW-1:0] HALF_O = SW'(1) <<< (OS - 1);
   localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
   localparam logic signed [FW-1:0] ONE    = FW'(1) <<< FRAC_BITS;

   logic v0_ff, v1_ff, v2_ff, v3_ff;

   logic signed [CW-1:0] cr, sr;
   logic signed [FW-1:0] c_in;
   logic signed [FW-1:0] c0_ff, s0_ff, t0_ff, c1_ff;
   logic signed [31:0]   pp_ff [6];
   logic signed [15:0]   ax_ff, ay_ff, az_ff;
   logic signed [FW+31:0] pt_ff [6];
   logic signed [FW+15:0] ps_ff [3];
   logic signed [SW-1:0] cc, tt [6], ss [3];
   logic signed [SW-1:0] sum_ff [9];
   logic signed [SW-1:0] rr [9];
   logic signed [17:0]   m_ff [9];

   // Round the CORDIC outputs to FRAC_BITS and apply the half-turn flip.
   always_comb begin
      cr   = (in_word.x + HALF_R) >>> RS;
      sr   = (in_word.y + HALF_R) >>> RS;
      c_in = in_word.aux.flip ? -cr[FW-1:0] : cr[FW-1:0];
   end

   // Widen the products to the common sum format.
   always_comb begin
      cc = SW'(c1_ff) <<< 28;
      for (int i = 0; i < 6; i++) begin
         tt[i] = SW'(pt_ff[i]);
      end
      for (int i = 0; i < 3; i++) begin
         ss[i] = SW'(ps_ff[i]) <<< 14;
      end
      for (int i = 0; i < 9; i++) begin
         rr[i] = sum_ff[i] >>> OS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // Stage 0: c, s, t and axis pair products.
         c0_ff    <= c_in;
         s0_ff    <= sr[FW-1:0];
         t0_ff    <= ONE - c_in;
         pp_ff[0] <= in_word.aux.ax * in_word.aux.ax;
         pp_ff[1] <= in_word.aux.ay * in_word.aux.ay;
         pp_ff[2] <= in_word.aux.az * in_word.aux.az;
         pp_ff[3] <= in_word.aux.ax * in_word.aux.ay;
         pp_ff[4] <= in_word.aux.ax * in_word.aux.az;
         pp_ff[5] <= in_word.aux.ay * in_word.aux.az;
         ax_ff    <= in_word.aux.ax;
         ay_ff    <= in_word.aux.ay;
         az_ff    <= in_word.aux.az;

         // Stage 1: scale by t and s.
         for (int i = 0; i < 6; i++) begin
            pt_ff[i] <= t0_ff * pp_ff[i];
         end
         ps_ff[0] <= s0_ff * ax_ff;
         ps_ff[1] <= s0_ff * ay_ff;
         ps_ff[2] <= s0_ff * az_ff;
         c1_ff    <= c0_ff;

         // Stage 2: entry sums with the rounding half folded in.
         sum_ff[0] <= cc + tt[0] + HALF_O;
         sum_ff[1] <= tt[3] - ss[2] + HALF_O;
         sum_ff[2] <= tt[4] + ss[1] + HALF_O;
         sum_ff[3] <= tt[3] + ss[2] + HALF_O;
         sum_ff[4] <= cc + tt[1] + HALF_O;
         sum_ff[5] <= tt[5] - ss[0] + HALF_O;
         sum_ff[6] <= tt[4] - ss[1] + HALF_O;
         sum_ff[7] <= tt[5] + ss[0] + HALF_O;
         sum_ff[8] <= cc + tt[2] + HALF_O;

         // Stage 3: drop fraction bits and saturate.
         for (int i = 0; i < 9; i++) begin
            if (rr[i] > SAT_HI) begin
               m_ff[i] <= SAT_HI[17:0];
            end else if (rr[i] < SAT_LO) begin
               m_ff[i] <= SAT_LO[17:0];
            end else begin
               m_ff[i] <= rr[i][17:0];
            end
         end
      end
   end

   assign out_valid = v3_ff;
   assign entry     = m_ff;

endmodule

`default_nettype wire

// ----- rtl/core/axis_angle_rotation_matrix.sv -----
// Top level of the axis-angle rotation matrix block (Rodrigues' formula).
// Instantiates aarm_front, a chain of aarm_cordic_cell and aarm_matrix; uses aarm_pkg.
//
// Takes one word per cycle while it is not stalled: an angle in 1/256 degree and an
// unnormalized Q1.14 axis, and returns the nine Q3.14 entries of the rotation matrix,
// row-major, saturated. The pipeline accepts a new word every cycle unless stalled;
// it has three stages of angle conversion, one cell per CORDIC step, three
// arithmetic stages and the output register. The whole pipeline advances together
// and holds while a result waits on rsp_tready, so req_tready follows rsp_tready
// whenever a result is pending.
`default_nettype none

module axis_angle_rotation_matrix #(
   parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = aarm_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // angle_deg[17:0], axis_x[33:18], axis_y[49:34], axis_z[65:50], zeros above
   input  wire logic [aarm_pkg::IN_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // m00[17:0], m01, m02, m10, m11, m12, m20, m21, m22[161:144], zeros above
   output logic [aarm_pkg::OUT_DATA_W-1:0]         rsp_tdata
);
   import aarm_pkg::*;

   logic               en;
   logic               vld [CORDIC_STEPS+1];
   cordic_type         stg [CORDIC_STEPS+1];
   logic signed [17:0] entry [9];

   // One enable for every stage: move unless a result is stuck.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   aarm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .angle     (signed'(req_tdata[17:0])),
      .ax        (signed'(req_tdata[33:18])),
      .ay        (signed'(req_tdata[49:34])),
      .az        (signed'(req_tdata[65:50])),
      .out_valid (vld[0]),
      .out_word  (stg[0])
   );

   // CORDIC chain, one cell per step.
   for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cell
      aarm_cordic_cell #(.IDX(gi)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vld[gi]),
         .in_word   (stg[gi]),
         .out_valid (vld[gi+1]),
         .out_word  (stg[gi+1])
      );
   end

   aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld[CORDIC_STEPS]),
      .in_word   (stg[CORDIC_STEPS]),
      .out_valid (rsp_tvalid),
      .entry     (entry)
   );

   // Pack the nine entries, first in the lowest bits.
   assign rsp_tdata = {6'd0, entry[8], entry[7], entry[6], entry[5], entry[4],
                       entry[3], entry[2], entry[1], entry[0]};

endmodule

`default_nettype wire

// ----- rtl/core/aarm_checker.sv -----
// Port-level checker of the rotation matrix block and its bind statement.
// Uses the macros of axis_angle_rotation_matrix_assert.svh.
`default_nettype none

`include "axis_angle_rotation_matrix_assert.svh"

module aarm_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [167:0] rsp_tdata
);

   // A waiting result is not dropped.
   `AARM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // A stalled pipeline takes no new word.
   `AARM_ASSERT_IMPL(a_stall_no_accept, rsp_tvalid && !rsp_tready, !req_tready)

   // The pipeline moves whenever the output side is free.
   `AARM_ASSERT_IMPL(a_free_accept, !rsp_tvalid || rsp_tready, req_tready)

   // Padding bits above the last entry stay zero.
   `AARM_ASSERT_IMPL(a_pad_zero, rsp_tvalid, rsp_tdata[167:162] == 6'd0)

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (.*);

`default_nettype wire
